// ===== rtl/cbt_pkg.sv =====
// Shared widths, constants and beat types of the cubic Bezier tessellator.
package cbt_pkg;

  localparam int COORD_W  = 16;
  localparam int N_PTS    = 4;
  localparam int N_AXES   = 3;
  localparam int N_COORDS = N_PTS * N_AXES;
  localparam int SEG_W    = 6;
  localparam int T_FRAC   = 16;
  localparam int T_W      = T_FRAC + 1;
  localparam int CNT_W    = $clog2(T_W);
  localparam int SQ_W     = 2 * T_FRAC + 1;
  localparam int CU_W     = 3 * T_FRAC + 2;
  localparam int RND_W    = CU_W + 1;
  localparam int PROD_W   = T_W + 1 + COORD_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int V_W      = SUM_W - T_FRAC;
  localparam int IN_W     = N_COORDS * COORD_W;
  localparam int OUT_W    = N_AXES * COORD_W;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(50);
  localparam logic [T_W-1:0]   T_ONE     = T_W'(1) << T_FRAC;
  localparam logic [RND_W-1:0] W_HALF    = RND_W'(1) << (2 * T_FRAC - 1);
  localparam logic signed [SUM_W-1:0] S_HALF = SUM_W'(1) << (T_FRAC - 1);
  localparam logic signed [V_W-1:0]   V_MAX  = V_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [V_W-1:0]   V_MIN  = -V_MAX - V_W'(1);

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    tag_t                        tag;
    logic [N_PTS-1:0][T_W-1:0]   w;
  } wgt_beat_t;

endpackage

// ===== rtl/cbt_recip.sv =====
// Bit-serial divider giving 2^16 / n as quotient and remainder.
module cbt_recip (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cbt_pkg::SEG_W-1:0]  n,
  output logic                       busy,
  output logic [cbt_pkg::T_W-1:0]    quo,
  output logic [cbt_pkg::SEG_W-1:0]  rem
);

  logic                       busy_r;
  logic [cbt_pkg::CNT_W-1:0]  cnt_r;
  logic [cbt_pkg::SEG_W-1:0]  rem_r;
  logic [cbt_pkg::T_W-1:0]    quo_r;
  logic [cbt_pkg::SEG_W:0]    rem_sh;
  logic [cbt_pkg::SEG_W:0]    diff;
  logic                       ge;
  logic [cbt_pkg::SEG_W-1:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, (cnt_r == cbt_pkg::CNT_W'(cbt_pkg::T_W - 1))};
    ge      = rem_sh >= {1'b0, n};
    diff    = rem_sh - {1'b0, n};
    rem_nxt = ge ? diff[cbt_pkg::SEG_W-1:0] : rem_sh[cbt_pkg::SEG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      cnt_r  <= cbt_pkg::CNT_W'(cbt_pkg::T_W - 1);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[cbt_pkg::T_W-2:0], ge};
      cnt_r <= cnt_r - cbt_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

`ifndef NO_ASSERTIONS
  a_quo_exact: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (24'(quo_r) * 24'(n) + 24'(rem_r)) == 24'(cbt_pkg::T_ONE))
    else $error("reciprocal quotient wrong");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> rem_r < n)
    else $error("reciprocal remainder not below n");
`endif

endmodule

// ===== rtl/cbt_weight.sv =====
// Parameter sequencer and Bernstein weight pipeline.
module cbt_weight (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       start,
  input  logic [cbt_pkg::SEG_W-1:0]  n,
  input  logic [cbt_pkg::T_W-1:0]    step_q,
  input  logic [cbt_pkg::SEG_W-1:0]  step_r,
  output logic                       busy,
  output cbt_pkg::wgt_beat_t         wb
);

  logic                       busy_r;
  logic [cbt_pkg::SEG_W-1:0]  idx_r;
  logic [cbt_pkg::T_W-1:0]    t_r;
  logic [cbt_pkg::SEG_W-1:0]  r_r;
  logic [cbt_pkg::SEG_W:0]    r_sum;
  logic [cbt_pkg::SEG_W:0]    r_wrap;
  logic                       wrap;
  logic [cbt_pkg::SEG_W-1:0]  r_nxt;
  logic [cbt_pkg::T_W-1:0]    t_nxt;
  logic [cbt_pkg::T_W-1:0]    u_c;
  logic                       last_c;

  cbt_pkg::tag_t              s1_tag_r, s2_tag_r, s3_tag_r;
  logic [cbt_pkg::T_W-1:0]    s1_t_r, s1_u_r;
  logic [cbt_pkg::SQ_W-1:0]   s1_tt_r, s1_uu_r;
  logic [cbt_pkg::CU_W-1:0]   s2_a_r, s2_b_r, s2_c_r, s2_d_r;
  logic [cbt_pkg::N_PTS-1:0][cbt_pkg::T_W-1:0] s3_w_r;
  logic [cbt_pkg::RND_W-1:0]  ra, rb, rc, rd;

  always_comb begin
    r_sum  = {1'b0, r_r} + {1'b0, step_r};
    wrap   = r_sum >= {1'b0, n};
    r_wrap = r_sum - {1'b0, n};
    r_nxt  = wrap ? r_wrap[cbt_pkg::SEG_W-1:0] : r_sum[cbt_pkg::SEG_W-1:0];
    t_nxt  = t_r + step_q + cbt_pkg::T_W'(wrap);
    u_c    = cbt_pkg::T_ONE - t_r;
    last_c = idx_r == n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (en && busy_r && last_c) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
      t_r   <= '0;
      r_r   <= n >> 1;
    end else if (en && busy_r) begin
      idx_r <= idx_r + cbt_pkg::SEG_W'(1);
      t_r   <= t_nxt;
      r_r   <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else if (en) begin
      s1_tag_r <= '{valid: busy_r, last: last_c};
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  always_comb begin
    ra = cbt_pkg::RND_W'(s2_a_r) + cbt_pkg::W_HALF;
    rb = (cbt_pkg::RND_W'(s2_b_r) << 1) + cbt_pkg::RND_W'(s2_b_r) + cbt_pkg::W_HALF;
    rc = (cbt_pkg::RND_W'(s2_c_r) << 1) + cbt_pkg::RND_W'(s2_c_r) + cbt_pkg::W_HALF;
    rd = cbt_pkg::RND_W'(s2_d_r) + cbt_pkg::W_HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r    <= t_r;
      s1_u_r    <= u_c;
      s1_tt_r   <= cbt_pkg::SQ_W'(t_r) * cbt_pkg::SQ_W'(t_r);
      s1_uu_r   <= cbt_pkg::SQ_W'(u_c) * cbt_pkg::SQ_W'(u_c);
      s2_a_r    <= cbt_pkg::CU_W'(s1_uu_r) * cbt_pkg::CU_W'(s1_u_r);
      s2_b_r    <= cbt_pkg::CU_W'(s1_uu_r) * cbt_pkg::CU_W'(s1_t_r);
      s2_c_r    <= cbt_pkg::CU_W'(s1_tt_r) * cbt_pkg::CU_W'(s1_u_r);
      s2_d_r    <= cbt_pkg::CU_W'(s1_tt_r) * cbt_pkg::CU_W'(s1_t_r);
      s3_w_r[0] <= ra[2*cbt_pkg::T_FRAC +: cbt_pkg::T_W];
      s3_w_r[1] <= rb[2*cbt_pkg::T_FRAC +: cbt_pkg::T_W];
      s3_w_r[2] <= rc[2*cbt_pkg::T_FRAC +: cbt_pkg::T_W];
      s3_w_r[3] <= rd[2*cbt_pkg::T_FRAC +: cbt_pkg::T_W];
    end
  end

  assign busy   = busy_r | s1_tag_r.valid | s2_tag_r.valid | s3_tag_r.valid;
  assign wb.tag = s3_tag_r;
  assign wb.w   = s3_w_r;

`ifndef NO_ASSERTIONS
  a_last_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tag_r.valid && s1_tag_r.last |-> s1_t_r == cbt_pkg::T_ONE)
    else $error("final vertex without t equal to one");
  a_inner_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tag_r.valid && !s1_tag_r.last |-> s1_t_r < cbt_pkg::T_ONE)
    else $error("inner vertex reached t of one");
`endif

endmodule

// ===== rtl/cbt_lane.sv =====
// One axis lane: weighted products of the four points and their sum.
module cbt_lane (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic [cbt_pkg::N_PTS-1:0][cbt_pkg::T_W-1:0]       w,
  input  logic [cbt_pkg::N_PTS-1:0][cbt_pkg::COORD_W-1:0]   pts,
  output logic signed [cbt_pkg::SUM_W-1:0]                  sum
);

  logic signed [cbt_pkg::PROD_W-1:0] prod_r [cbt_pkg::N_PTS];
  logic signed [cbt_pkg::SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < cbt_pkg::N_PTS; k++) begin
        prod_r[k] <= $signed({1'b0, w[k]}) * $signed(pts[k]);
      end
      sum_r <= cbt_pkg::SUM_W'(prod_r[0]) + cbt_pkg::SUM_W'(prod_r[1])
             + cbt_pkg::SUM_W'(prod_r[2]) + cbt_pkg::SUM_W'(prod_r[3]);
    end
  end

  assign sum = sum_r;

endmodule

// ===== rtl/cbt_merge.sv =====
// Joins the lane sums into one rounded, saturated vertex beat.
module cbt_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cbt_pkg::tag_t                       tag,
  input  logic signed [cbt_pkg::SUM_W-1:0]    sum_x,
  input  logic signed [cbt_pkg::SUM_W-1:0]    sum_y,
  input  logic signed [cbt_pkg::SUM_W-1:0]    sum_z,
  output logic                                en,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cbt_pkg::OUT_W-1:0]           out_tdata,
  output logic                                out_tlast
);

  cbt_pkg::tag_t                  s4_tag_r, s5_tag_r;
  logic                           vld_r;
  logic                           last_r;
  logic [cbt_pkg::OUT_W-1:0]      data_r;

  function automatic logic [cbt_pkg::COORD_W-1:0] rnd_sat(
    input logic signed [cbt_pkg::SUM_W-1:0] s
  );
    logic signed [cbt_pkg::SUM_W-1:0] r;
    logic signed [cbt_pkg::V_W-1:0]   v;
    logic signed [cbt_pkg::V_W-1:0]   c;
    r = s + cbt_pkg::S_HALF;
    v = $signed(r[cbt_pkg::SUM_W-1:cbt_pkg::T_FRAC]);
    if (v > cbt_pkg::V_MAX) begin
      c = cbt_pkg::V_MAX;
    end else if (v < cbt_pkg::V_MIN) begin
      c = cbt_pkg::V_MIN;
    end else begin
      c = v;
    end
    return c[cbt_pkg::COORD_W-1:0];
  endfunction

  assign en = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r <= '0;
      s5_tag_r <= '0;
      vld_r    <= 1'b0;
    end else if (en) begin
      s4_tag_r <= tag;
      s5_tag_r <= s4_tag_r;
      vld_r    <= s5_tag_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= s5_tag_r.last;
      data_r <= {rnd_sat(sum_z), rnd_sat(sum_y), rnd_sat(sum_x)};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_r;
  assign out_tdata  = data_r;

endmodule

// ===== rtl/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator top level: control points in, curve vertices out.
//
// in_*  : one beat carries the four control points P0..P3 (x, y, z each, Q4.12).
// out_* : one beat per vertex, t = i/n for i = 0..n; tlast marks t = 1.
// cfg_* : writes segment_count n (0 acts as 1); reset value 50.
// An item gives n+1 vertex beats, one per cycle while out_tready is high.
// The next input beat is taken once the last vertex has left the weight
// pipeline. The per-vertex work is a three-stage weight pipeline followed
// by three axis lanes of two stages each and a merge output register.
// After reset and after every cfg write a bit-serial divider forms the
// parameter step 2^16/n; in_tready stays low meanwhile.
// Reset is synchronous, active low; it empties the pipeline and loads n = 50.
// When out_tready is low while an output beat waits, the whole vertex pipeline holds; no beat is lost.
module cubic_bezier_tessellator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbt_pkg::SEG_W-1:0]     cfg_data,   // segment_count
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [cbt_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cbt_pkg::OUT_W-1:0]     out_tdata,  // vert_x, vert_y, vert_z
  output logic                          out_tlast   // final_vertex
);

  logic [cbt_pkg::SEG_W-1:0]    seg_r;
  logic [cbt_pkg::SEG_W-1:0]    n_eff;
  logic [cbt_pkg::COORD_W-1:0]  pts_r [cbt_pkg::N_COORDS];
  logic                         cfg_acc;
  logic                         in_acc;
  logic                         div_busy;
  logic [cbt_pkg::T_W-1:0]      step_q;
  logic [cbt_pkg::SEG_W-1:0]    step_r;
  logic                         wgt_busy;
  logic                         en;
  cbt_pkg::wgt_beat_t           wb;
  logic signed [cbt_pkg::SUM_W-1:0] lane_sum [cbt_pkg::N_AXES];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = !div_busy && !wgt_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign n_eff     = (seg_r == '0) ? cbt_pkg::SEG_W'(1) : seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= cbt_pkg::SEG_RESET;
    end else if (cfg_acc) begin
      seg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < cbt_pkg::N_COORDS; k++) begin
        pts_r[k] <= in_tdata[k*cbt_pkg::COORD_W +: cbt_pkg::COORD_W];
      end
    end
  end

  cbt_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_acc),
    .n     (n_eff),
    .busy  (div_busy),
    .quo   (step_q),
    .rem   (step_r)
  );

  cbt_weight u_weight (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .start  (in_acc),
    .n      (n_eff),
    .step_q (step_q),
    .step_r (step_r),
    .busy   (wgt_busy),
    .wb     (wb)
  );

  for (genvar ax = 0; ax < cbt_pkg::N_AXES; ax++) begin : g_lane
    cbt_lane u_lane (
      .clk (clk),
      .en  (en),
      .w   (wb.w),
      .pts ({pts_r[3*cbt_pkg::N_AXES + ax], pts_r[2*cbt_pkg::N_AXES + ax],
             pts_r[cbt_pkg::N_AXES + ax], pts_r[ax]}),
      .sum (lane_sum[ax])
    );
  end

  cbt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (wb.tag),
    .sum_x      (lane_sum[0]),
    .sum_y      (lane_sum[1]),
    .sum_z      (lane_sum[2]),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");
  a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input ready before step recomputed");
`endif

endmodule
